[rtl/rmm_pkg.sv]
`timescale 1ns / 1ps
package rmm_pkg;

  localparam int RMM_POSITIONS = 1024;
  localparam int IDX_W = 10;
  localparam int CFG_W = 11;
  localparam int RES_W = 10;

  localparam logic [1:0] ACT_INIT   = 2'd0;
  localparam logic [1:0] ACT_SWAP   = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
  } rmm_in_t;

  typedef struct packed {
    logic [RES_W-1:0] range_min;
    logic [RES_W-1:0] range_max;
    logic             exact_range;
  } rmm_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] used_size;
  } rmm_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B_INIT,
    ST_B_LRD,
    ST_B_LWR,
    ST_B_NRD,
    ST_B_NWR,
    ST_S_RD,
    ST_S_WA,
    ST_S_WB,
    ST_U_RD,
    ST_U_WR,
    ST_U_LEAF,
    ST_Q_RD,
    ST_Q_CMB,
    ST_Q_DONE
  } rmm_state_t;

endpackage

[rtl/rmm_stream_if.sv]
`timescale 1ns / 1ps
interface rmm_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/range_min_max_tree_swap.sv]
`timescale 1ns / 1ps
// channel  | dir | payload                              | handshake
// in_if    | in  | action, index_a, index_b             | valid & ready
// out_if   | out | range_min, range_max, exact_range    | valid & ready
// cfg_if   | in  | used_size                            | valid & ready
//
// query: walks the tree levels from the leaves upward, combining nodes;
// swap: rewrites both position values and updates both leaf-to-root paths,
// paced by the single write port of the tree memory and its registered read.
// initialize: identity leaves, then nodes; size write: leaves from value memory, then nodes.
// after reset the identity build runs, no item taken.
// a finished query result waits in the output register; a new item may be taken meanwhile.
module range_min_max_tree_swap
  import rmm_pkg::*;
#(
  parameter int POSITIONS = RMM_POSITIONS
) (
  input  logic         clk,
  input  logic         rst_n,
  rmm_stream_if.sink   in_if,
  rmm_stream_if.source out_if,
  rmm_stream_if.sink   cfg_if
);

  localparam int PI_W = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int VAL_W = PI_W;
  localparam int NA_W = PI_W + 1;
  localparam int LR_W = NA_W + 1;
  localparam int SZ_W = ($clog2(POSITIONS + 1) > CFG_W) ? $clog2(POSITIONS + 1) : CFG_W;
  localparam int CW = (VAL_W > IDX_W) ? VAL_W : IDX_W;
  localparam int SIZE_RST = (POSITIONS < 1024) ? POSITIONS : 1024;
  localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};

  rmm_state_t state_r, state_nxt;

  logic [SZ_W-1:0]  size_r;
  logic [PI_W:0]    cnt_r;
  logic [NA_W-1:0]  k_r;
  logic             second_r;
  logic [IDX_W-1:0] a_r, b_r;
  logic [VAL_W-1:0] va_r, vb_r;
  logic [LR_W-1:0]  l_r, r_r;
  logic [VAL_W-1:0] mn_r, mx_r;
  logic             out_valid_r;
  rmm_out_t         out_data_r;

  // position value memory
  logic              pv_we;
  logic [PI_W-1:0]   pv_waddr, pv_raddr0, pv_raddr1;
  logic [VAL_W-1:0]  pv_wdata, pv_rdata0, pv_rdata1;
  // tree memory, {min, max}
  logic                tr_we;
  logic [NA_W-1:0]     tr_waddr, tr_raddr0, tr_raddr1;
  logic [2*VAL_W-1:0]  tr_wdata, tr_rdata0, tr_rdata1;

  rmm_ram #(.DATA_W(VAL_W), .ADDR_W(PI_W), .DEPTH(POSITIONS)) u_pv (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr0(pv_raddr0), .raddr1(pv_raddr1), .rdata0(pv_rdata0), .rdata1(pv_rdata1)
  );

  rmm_ram #(.DATA_W(2*VAL_W), .ADDR_W(NA_W), .DEPTH(2*POSITIONS)) u_tree (
    .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
    .raddr0(tr_raddr0), .raddr1(tr_raddr1), .rdata0(tr_rdata0), .rdata1(tr_rdata1)
  );

  function automatic logic [NA_W-1:0] leaf_addr(input logic [PI_W-1:0] pos);
    leaf_addr = NA_W'(POSITIONS) + NA_W'(pos);
  endfunction

  function automatic logic [2*VAL_W-1:0] join_nodes(input logic [2*VAL_W-1:0] x,
                                                    input logic [2*VAL_W-1:0] y);
    logic [VAL_W-1:0] lo, hi;
    lo = (x[2*VAL_W-1:VAL_W] < y[2*VAL_W-1:VAL_W]) ? x[2*VAL_W-1:VAL_W] : y[2*VAL_W-1:VAL_W];
    hi = (x[VAL_W-1:0] > y[VAL_W-1:0]) ? x[VAL_W-1:0] : y[VAL_W-1:0];
    join_nodes = {lo, hi};
  endfunction

  logic in_fire, cfg_fire, out_fire, out_load;
  logic cnt_last, cnt_used;
  logic [PI_W-1:0] cnt_pos;
  logic a_in, b_in, q_empty;
  logic [SZ_W-1:0] q_hi;
  logic [CFG_W-1:0] cfg_val;
  logic [SZ_W-1:0] cfg_clamped;
  logic [VAL_W-1:0] mn_cmb, mx_cmb, mn_step, mx_step;
  logic [LR_W-1:0] l_inc, r_dec;

  assign in_fire  = in_if.valid & in_if.ready;
  assign cfg_fire = cfg_if.valid & cfg_if.ready;
  assign out_fire = out_if.valid & out_if.ready;
  assign out_load = (state_r == ST_Q_DONE) && (!out_valid_r || out_if.ready);

  assign cnt_pos  = cnt_r[PI_W-1:0];
  assign cnt_last = (cnt_r == (PI_W+1)'(POSITIONS - 1));
  assign cnt_used = (SZ_W'(cnt_r) < size_r);

  assign a_in    = SZ_W'(in_if.data.index_a) < size_r;
  assign b_in    = SZ_W'(in_if.data.index_b) < size_r;
  assign q_empty = (in_if.data.index_a > in_if.data.index_b) || !a_in;
  assign q_hi    = b_in ? SZ_W'(in_if.data.index_b) : size_r - SZ_W'(1);

  assign cfg_val = cfg_if.data.used_size;
  always_comb begin
    if (cfg_val == '0) begin
      cfg_clamped = SZ_W'(1);
    end else if (SZ_W'(cfg_val) > SZ_W'(POSITIONS)) begin
      cfg_clamped = SZ_W'(POSITIONS);
    end else begin
      cfg_clamped = SZ_W'(cfg_val);
    end
  end

  // query step: left node if l odd, right node r-1 if r odd
  always_comb begin
    mn_step = mn_r;
    mx_step = mx_r;
    if (l_r[0]) begin
      mn_step = (tr_rdata0[2*VAL_W-1:VAL_W] < mn_step) ? tr_rdata0[2*VAL_W-1:VAL_W] : mn_step;
      mx_step = (tr_rdata0[VAL_W-1:0] > mx_step) ? tr_rdata0[VAL_W-1:0] : mx_step;
    end
    if (r_r[0]) begin
      mn_step = (tr_rdata1[2*VAL_W-1:VAL_W] < mn_step) ? tr_rdata1[2*VAL_W-1:VAL_W] : mn_step;
      mx_step = (tr_rdata1[VAL_W-1:0] > mx_step) ? tr_rdata1[VAL_W-1:0] : mx_step;
    end
    mn_cmb = mn_step;
    mx_cmb = mx_step;
  end
  assign l_inc = l_r + (l_r[0] ? LR_W'(1) : LR_W'(0));
  assign r_dec = r_r - (r_r[0] ? LR_W'(1) : LR_W'(0));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_fire) begin
          state_nxt = ST_B_LRD;
        end else if (in_fire) begin
          case (in_if.data.action)
            ACT_INIT:  state_nxt = ST_B_INIT;
            ACT_SWAP:  state_nxt = (a_in && b_in) ? ST_S_RD : ST_IDLE;
            ACT_QUERY: state_nxt = q_empty ? ST_Q_DONE : ST_Q_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_B_INIT: state_nxt = cnt_last ? ST_B_NRD : ST_B_INIT;
      ST_B_LRD:  state_nxt = ST_B_LWR;
      ST_B_LWR:  state_nxt = cnt_last ? ST_B_NRD : ST_B_LRD;
      ST_B_NRD:  state_nxt = ST_B_NWR;
      ST_B_NWR:  state_nxt = (k_r == NA_W'(1)) ? ST_IDLE : ST_B_NRD;
      ST_S_RD:   state_nxt = ST_S_WA;
      ST_S_WA:   state_nxt = ST_S_WB;
      ST_S_WB:   state_nxt = ST_U_RD;
      ST_U_RD:   state_nxt = ST_U_WR;
      ST_U_WR: begin
        if (k_r == NA_W'(1)) begin
          state_nxt = second_r ? ST_IDLE : ST_U_LEAF;
        end else begin
          state_nxt = ST_U_RD;
        end
      end
      ST_U_LEAF: state_nxt = ST_U_RD;
      ST_Q_RD:   state_nxt = (l_r < r_r) ? ST_Q_CMB : ST_Q_DONE;
      ST_Q_CMB:  state_nxt = ST_Q_RD;
      ST_Q_DONE: state_nxt = (!out_valid_r || out_if.ready) ? ST_IDLE : ST_Q_DONE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_if.ready  = 1'b0;
    cfg_if.ready = 1'b0;
    pv_we     = 1'b0;
    pv_waddr  = cnt_pos;
    pv_wdata  = VAL_W'(cnt_r);
    pv_raddr0 = cnt_pos;
    pv_raddr1 = PI_W'(b_r);
    tr_we     = 1'b0;
    tr_waddr  = k_r;
    tr_wdata  = join_nodes(tr_rdata0, tr_rdata1);
    tr_raddr0 = NA_W'({k_r, 1'b0});
    tr_raddr1 = NA_W'({k_r, 1'b1});
    unique case (state_r)
      ST_IDLE: begin
        cfg_if.ready = 1'b1;
        in_if.ready  = !cfg_if.valid;
      end
      ST_B_INIT: begin
        pv_we    = 1'b1;
        tr_we    = 1'b1;
        tr_waddr = leaf_addr(cnt_pos);
        tr_wdata = cnt_used ? {VAL_W'(cnt_r), VAL_W'(cnt_r)} : {ALL_ONES, VAL_W'(0)};
      end
      ST_B_LRD: begin
        pv_raddr0 = cnt_pos;
      end
      ST_B_LWR: begin
        tr_we    = 1'b1;
        tr_waddr = leaf_addr(cnt_pos);
        tr_wdata = cnt_used ? {pv_rdata0, pv_rdata0} : {ALL_ONES, VAL_W'(0)};
      end
      ST_B_NRD, ST_U_RD: begin
      end
      ST_B_NWR, ST_U_WR: begin
        tr_we = 1'b1;
      end
      ST_S_RD: begin
        pv_raddr0 = PI_W'(a_r);
        pv_raddr1 = PI_W'(b_r);
      end
      ST_S_WA: begin
        pv_we    = 1'b1;
        pv_waddr = PI_W'(a_r);
        pv_wdata = pv_rdata1;
      end
      ST_S_WB: begin
        pv_we    = 1'b1;
        pv_waddr = PI_W'(b_r);
        pv_wdata = va_r;
        tr_we    = 1'b1;
        tr_waddr = leaf_addr(PI_W'(a_r));
        tr_wdata = {vb_r, vb_r};
      end
      ST_U_LEAF: begin
        tr_we    = 1'b1;
        tr_waddr = leaf_addr(PI_W'(b_r));
        tr_wdata = {va_r, va_r};
      end
      ST_Q_RD: begin
        tr_raddr0 = l_r[NA_W-1:0];
        tr_raddr1 = r_r[NA_W-1:0] - NA_W'(1);
      end
      ST_Q_CMB, ST_Q_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_B_INIT;
      size_r      <= SZ_W'(SIZE_RST);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cfg_fire) begin
            size_r <= cfg_clamped;
            cnt_r  <= '0;
          end else if (in_fire) begin
            cnt_r <= '0;
            a_r   <= in_if.data.index_a;
            b_r   <= in_if.data.index_b;
            if (q_empty) begin
              mn_r <= '0;
              mx_r <= '0;
            end else begin
              mn_r <= ALL_ONES;
              mx_r <= '0;
            end
            l_r <= LR_W'(POSITIONS) + LR_W'(in_if.data.index_a);
            r_r <= LR_W'(POSITIONS) + LR_W'(q_hi) + LR_W'(1);
          end
        end
        ST_B_INIT, ST_B_LWR: begin
          cnt_r <= cnt_r + (PI_W+1)'(1);
          k_r   <= NA_W'(POSITIONS - 1);
        end
        ST_B_NWR: begin
          k_r <= k_r - NA_W'(1);
        end
        ST_S_WA: begin
          va_r <= pv_rdata0;
          vb_r <= pv_rdata1;
        end
        ST_S_WB: begin
          k_r      <= leaf_addr(PI_W'(a_r)) >> 1;
          second_r <= 1'b0;
        end
        ST_U_WR: begin
          k_r <= k_r >> 1;
        end
        ST_U_LEAF: begin
          k_r      <= leaf_addr(PI_W'(b_r)) >> 1;
          second_r <= 1'b1;
        end
        ST_Q_CMB: begin
          mn_r <= mn_cmb;
          mx_r <= mx_cmb;
          l_r  <= l_inc >> 1;
          r_r  <= r_dec >> 1;
        end
        ST_Q_DONE: begin
          if (out_load) begin
            out_data_r.range_min   <= RES_W'(mn_r);
            out_data_r.range_max   <= RES_W'(mx_r);
            out_data_r.exact_range <= (CW'(mn_r) == CW'(a_r)) && (CW'(mx_r) == CW'(b_r));
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_swap_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_if.data.action == ACT_SWAP && !a_in) |=> (state_r == ST_IDLE))
    else $error("swap outside used range was not ignored");

  a_query_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_Q_RD) |-> (r_r <= LR_W'(2 * POSITIONS)) && (l_r <= r_r + LR_W'(1)))
    else $error("query bounds out of tree");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_Q_DONE && (!out_valid_r || out_if.ready)) |=> out_valid_r)
    else $error("query result not loaded");
`endif

endmodule

[rtl/rmm_ram.sv]
`timescale 1ns / 1ps
module rmm_ram #(
  parameter int DATA_W = 10,
  parameter int ADDR_W = 10,
  parameter int DEPTH  = 1024
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [DATA_W-1:0] rdata0,
  output logic [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

[tb/tb_range_min_max_tree_swap.sv]
`timescale 1ns / 1ps
module tb_range_min_max_tree_swap
  import rmm_pkg::*;
();

  logic clk;
  logic rst_n;

  rmm_stream_if #(.payload_t(rmm_in_t))  in_if ();
  rmm_stream_if #(.payload_t(rmm_out_t)) out_if ();
  rmm_stream_if #(.payload_t(rmm_cfg_t)) cfg_if ();

  range_min_max_tree_swap DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // shadow copy of the permutation and the size register
  logic [IDX_W-1:0] perm [RMM_POSITIONS];
  int unsigned      size_now;

  rmm_out_t pending_results [$];
  int       mismatches;
  int       unexpected;
  int       hold_cycles;
  bit       quiet_sender;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #200_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    in_if.valid   <= 1'b0;
    in_if.data    <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= '0;
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else if (quiet_sender) begin
      out_if.ready <= 1'b1;
    end else if ($urandom_range(0, 19) == 0) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    rmm_out_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result min=%0d max=%0d exact=%0d",
                   out_if.data.range_min, out_if.data.range_max, out_if.data.exact_range);
      end else begin
        want = pending_results.pop_front();
        if (out_if.data.range_min !== want.range_min ||
            out_if.data.range_max !== want.range_max ||
            out_if.data.exact_range !== want.exact_range) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("mismatch: expected min=%0d max=%0d exact=%0d, got min=%0d max=%0d exact=%0d",
                     want.range_min, want.range_max, want.exact_range,
                     out_if.data.range_min, out_if.data.range_max, out_if.data.exact_range);
        end
      end
    end
  end

  function automatic void load_identity();
    for (int i = 0; i < RMM_POSITIONS; i++) perm[i] = i[IDX_W-1:0];
  endfunction

  // returns 1 when the item gives a result
  function automatic bit predict_range(rmm_in_t it, output rmm_out_t res);
    int unsigned a, b, hi, mn, mx;
    logic [IDX_W-1:0] t;
    a = it.index_a;
    b = it.index_b;
    res = '0;
    case (it.action)
      ACT_INIT: begin
        load_identity();
        return 1'b0;
      end
      ACT_SWAP: begin
        if (a < size_now && b < size_now) begin
          t = perm[a];
          perm[a] = perm[b];
          perm[b] = t;
        end
        return 1'b0;
      end
      ACT_QUERY: begin
        if (a > b || a >= size_now) return 1'b1;
        hi = (b < size_now) ? b : size_now - 1;
        mn = 32'hFFFF_FFFF;
        mx = 0;
        for (int unsigned i = a; i <= hi; i++) begin
          if (perm[i] < mn) mn = perm[i];
          if (perm[i] > mx) mx = perm[i];
        end
        res.range_min   = mn[RES_W-1:0];
        res.range_max   = mx[RES_W-1:0];
        res.exact_range = (mn == a && mx == b);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int pick_gap();
    if (quiet_sender) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_item(rmm_in_t it);
    int gap;
    rmm_out_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    if (predict_range(it, res)) pending_results.push_back(res);
  endtask

  task automatic send_op(logic [1:0] act, int a, int b);
    rmm_in_t it;
    it.action  = act;
    it.index_a = a[IDX_W-1:0];
    it.index_b = b[IDX_W-1:0];
    send_item(it);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // size write, only once the block has gone quiet
  task automatic write_size(int unsigned v);
    drain();
    repeat (5000) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data.used_size <= v[CFG_W-1:0];
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    v = v & 11'h7FF;
    size_now = (v < 1) ? 1 : (v > RMM_POSITIONS) ? RMM_POSITIONS : v;
  endtask

  function automatic int pick_index();
    if ($urandom_range(0, 9) != 0) return $urandom_range(0, size_now - 1);
    return $urandom_range(0, RMM_POSITIONS - 1);
  endfunction

  task automatic send_random();
    int k, a, b, t;
    k = $urandom_range(0, 99);
    a = pick_index();
    b = pick_index();
    if (k < 3) send_op(ACT_INIT, a, b);
    else if (k < 5) send_op(ACT_UNUSED, a, b);
    else if (k < 45) send_op(ACT_SWAP, a, b);
    else begin
      if (a > b && $urandom_range(0, 9) != 0) begin
        t = a;
        a = b;
        b = t;
      end
      send_op(ACT_QUERY, a, b);
    end
  endtask

  task automatic test_directed();
    send_op(ACT_QUERY, 0, 1023);
    send_op(ACT_QUERY, 0, 0);
    send_op(ACT_QUERY, 1023, 1023);
    send_op(ACT_SWAP, 0, 1023);
    send_op(ACT_QUERY, 0, 1023);
    send_op(ACT_QUERY, 0, 511);
    send_op(ACT_QUERY, 512, 1023);
    send_op(ACT_QUERY, 600, 300);
    send_op(ACT_UNUSED, 5, 9);
    send_op(ACT_SWAP, 5, 5);
    send_op(ACT_QUERY, 1, 1022);
    send_op(ACT_INIT, 0, 0);
    send_op(ACT_QUERY, 0, 1023);
    drain();
    write_size(100);
    send_op(ACT_QUERY, 100, 200);
    send_op(ACT_QUERY, 50, 500);
    send_op(ACT_SWAP, 10, 100);
    send_op(ACT_SWAP, 0, 99);
    send_op(ACT_QUERY, 0, 99);
    send_op(ACT_QUERY, 0, 0);
    send_op(ACT_QUERY, 99, 99);
    send_op(ACT_QUERY, 1023, 1023);
  endtask

  task automatic test_size_phases();
    int unsigned sizes [8] = '{0, 1, 2, 2047, 1024, 37, 300, 13};
    foreach (sizes[i]) begin
      write_size(sizes[i]);
      quiet_sender = ($urandom_range(0, 3) == 0);
      repeat (90) send_random();
      quiet_sender = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    write_size(64);
    hold_cycles = 600;
    repeat (40) send_random();
    // sender waits for every result before going on
    drain();
    repeat (60) send_random();
  endtask

  initial begin
    rst_n        = 1'b0;
    mismatches   = 0;
    unexpected   = 0;
    hold_cycles  = 0;
    quiet_sender = 1'b0;
    size_now     = RMM_POSITIONS;
    load_identity();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_size_phases();
    test_backpressure();

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
